/* design/wsi_pkg.sv */
// wsi_pkg: shared types, constants and elaboration-time weight maths for the
// windowed sinc interpolator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsi_pkg;

    localparam int DEF_TAP_RADIUS = 16;
    localparam int DEF_PHASE_BITS = 6;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;

    // register map and codes
    localparam logic REG_MODE_IDX = 1'b0;
    localparam logic MODE_LINEAR  = 1'b0;
    localparam logic MODE_SINC    = 1'b1;
    localparam logic FUNC_PUSH    = 1'b0;
    localparam logic FUNC_QUERY   = 1'b1;

    // fixed-point constants (Q30 / Q8.24 half-turns)
    localparam longint          Q30     = 64'sd1073741824;
    localparam longint          ONE24   = 64'sd16777216;
    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint          K042    = 64'sd450971566;
    localparam longint          K008    = 64'sd85899346;
    localparam logic [31:0]     T_MASK  = 32'h01FF_FFFF;
    localparam logic [31:0]     T_ONE   = 32'h0100_0000;
    localparam logic [31:0]     T_HALF  = 32'h0080_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINC,
        ST_LIN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                query;
        logic [SAMPLE_W-1:0] sample;
        logic [FRAC_W-1:0]   frac;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic res_valid;
    } t_sts;

    // restoring divide for the weight tables, quotient truncated
    function automatic longint unsigned f_udiv(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // signed divide, quotient truncated toward zero
    function automatic longint f_sdiv(input longint num, input longint den);
        longint unsigned mq;
        mq = f_udiv(unsigned'((num < 0) ? -num : num), unsigned'((den < 0) ? -den : den));
        return ((num < 0) != (den < 0)) ? -longint'(mq) : longint'(mq);
    endfunction

    // sin(pi*t), t in Q8.24 half-turns, result Q2.30
    function automatic longint f_sin_half_turns(input logic [31:0] t_in);
        logic [31:0]     t;
        logic            neg;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        t   = t_in & T_MASK;
        neg = (t >= T_ONE);
        if (neg) begin
            t = t - T_ONE;
        end
        if (t > T_HALF) begin
            t = T_ONE - t;
        end
        x    = ({32'd0, t} * PI_Q30) >> 24;
        x2   = (x * x) >> 30;
        term = longint'(Q30);
        for (int k = 12; k >= 2; k -= 2) begin
            term = longint'(Q30) - f_udiv((x2 * term) >> 30, 64'(k * (k + 1)));
        end
        x = (x * term) >> 30;
        return neg ? -longint'(x) : longint'(x);
    endfunction

    function automatic longint f_cos_half_turns(input logic [31:0] t);
        return f_sin_half_turns(t + T_HALF);
    endfunction

    // Q2.30 weight of one tap at offset d (Q8.24, signed)
    function automatic longint f_tap_weight(input longint d, input int radius);
        longint          mag;
        longint          snc;
        longint          bw;
        longint          num;
        longint unsigned den;
        logic [31:0]     u;
        mag = (d < 0) ? -d : d;
        if (mag > longint'(radius) * ONE24) begin
            return 0;
        end
        if (mag == 0) begin
            snc = Q30;
        end else begin
            num = f_sin_half_turns(d[31:0]);
            if (d < 0) begin
                num = -num;
            end
            den = (longint'(mag) * PI_Q30) >> 24;
            snc = f_sdiv(num * Q30, longint'(den));
        end
        u  = 32'(f_sdiv(mag, longint'(radius)));
        bw = K042 + f_cos_half_turns(u) / 2 + (K008 * f_cos_half_turns(u * 32'd2)) / Q30;
        return (snc * bw) / Q30;
    endfunction

endpackage

`default_nettype wire

/* design/wsi_core.sv */
// wsi_core: sample history, weight ROM, shared multiplier and the sequencer
// that walks the taps. Depends on wsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsi_core #(
    parameter int TAP_RADIUS = wsi_pkg::DEF_TAP_RADIUS,
    parameter int PHASE_BITS = wsi_pkg::DEF_PHASE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire wsi_pkg::t_cmd         i_cmd,
    input  wire logic                  i_mode,
    input  wire logic                  i_res_take,
    output wsi_pkg::t_sts              o_sts,
    output logic signed [15:0]         o_value
);

    localparam int TAPS      = 2 * TAP_RADIUS + 1;
    localparam int PHASES    = 1 << PHASE_BITS;
    localparam int ROM_DEPTH = PHASES * TAPS;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam int CNT_W     = $clog2(TAPS);
    localparam int MA_W      = wsi_pkg::SAMPLE_W + 1;
    localparam int MB_W      = 33;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int ACC_W     = PROD_W + $clog2(TAPS);

    localparam logic signed [ACC_W-1:0] RND_SINC = ACC_W'(1 << 29);
    localparam logic signed [ACC_W-1:0] RND_LIN  = ACC_W'(1 << 15);
    localparam logic signed [ACC_W:0]   SAT_MAX  = (ACC_W + 1)'(32767);
    localparam logic signed [ACC_W:0]   SAT_MIN  = -(ACC_W + 1)'(32768);

    typedef logic signed [31:0] t_rom [ROM_DEPTH];

    function automatic t_rom f_build_rom();
        t_rom   rom;
        longint w [TAPS];
        longint norm;
        longint q;
        longint r;
        for (int p = 0; p < PHASES; p++) begin
            r    = longint'(p) << (24 - PHASE_BITS);
            norm = 0;
            for (int i = 0; i < TAPS; i++) begin
                w[i] = wsi_pkg::f_tap_weight(
                    r - longint'(i - TAP_RADIUS) * wsi_pkg::ONE24, TAP_RADIUS);
                norm = norm + w[i];
            end
            for (int i = 0; i < TAPS; i++) begin
                q = (norm == 0) ? 0 : wsi_pkg::f_sdiv(w[i] * wsi_pkg::Q30, norm);
                if (q > 64'sd2147483647) begin
                    q = 64'sd2147483647;
                end
                if (q < -64'sd2147483648) begin
                    q = -64'sd2147483648;
                end
                rom[p * TAPS + i] = 32'(q);
            end
        end
        return rom;
    endfunction

    localparam t_rom WEIGHT_ROM = f_build_rom();

    wsi_pkg::t_state r_state, n_state;

    logic signed [15:0]       r_hist [TAPS];
    logic [CNT_W-1:0]         r_cnt;
    logic [ROM_AW-1:0]        r_base;
    logic [15:0]              r_frac;
    logic                     r_lin;
    logic signed [15:0]       r_a;
    logic signed [MA_W-1:0]   r_ma;
    logic signed [MB_W-1:0]   r_mb;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_v1;
    logic                     r_v2;

    logic [ROM_AW-1:0]        rom_addr;
    logic                     push;
    logic                     query;

    assign push     = i_start && (i_cmd.query == wsi_pkg::FUNC_PUSH);
    assign query    = i_start && (i_cmd.query == wsi_pkg::FUNC_QUERY);
    assign rom_addr = r_base + ROM_AW'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wsi_pkg::ST_IDLE: begin
                if (query) begin
                    n_state = (i_mode == wsi_pkg::MODE_SINC) ? wsi_pkg::ST_SINC
                                                             : wsi_pkg::ST_LIN;
                end
            end
            wsi_pkg::ST_SINC: begin
                if (r_cnt == '0) begin
                    n_state = wsi_pkg::ST_DRAIN;
                end
            end
            wsi_pkg::ST_LIN: begin
                n_state = wsi_pkg::ST_DRAIN;
            end
            wsi_pkg::ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = wsi_pkg::ST_DONE;
                end
            end
            wsi_pkg::ST_DONE: begin
                if (i_res_take) begin
                    n_state = wsi_pkg::ST_IDLE;
                end
            end
            default: n_state = wsi_pkg::ST_IDLE;
        endcase
    end

    // history: shift on push, rotate once per tap during a sinc walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_hist[i] <= '0;
            end
        end else if (r_state == wsi_pkg::ST_IDLE && push) begin
            r_hist[0] <= signed'(i_cmd.sample);
            for (int i = 1; i < TAPS; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end else if (r_state == wsi_pkg::ST_SINC) begin
            r_hist[TAPS-1] <= r_hist[0];
            for (int i = 0; i < TAPS - 1; i++) begin
                r_hist[i] <= r_hist[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= (r_state == wsi_pkg::ST_SINC) || (r_state == wsi_pkg::ST_LIN);
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == wsi_pkg::ST_IDLE && query) begin
            r_cnt  <= CNT_W'(TAPS - 1);
            r_base <= ROM_AW'(ROM_AW'(i_cmd.frac[15 -: PHASE_BITS]) * ROM_AW'(TAPS));
            r_frac <= i_cmd.frac;
            r_lin  <= (i_mode == wsi_pkg::MODE_LINEAR);
            r_acc  <= '0;
        end else begin
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            case (r_state)
                wsi_pkg::ST_SINC: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    r_ma  <= MA_W'(r_hist[0]);
                    r_mb  <= MB_W'(WEIGHT_ROM[rom_addr]);
                end
                wsi_pkg::ST_LIN: begin
                    r_a  <= r_hist[TAP_RADIUS];
                    r_ma <= MA_W'(r_hist[TAP_RADIUS-1]) - MA_W'(r_hist[TAP_RADIUS]);
                    r_mb <= signed'({{(MB_W - 16){1'b0}}, r_frac});
                end
                default: ;
            endcase
        end
        if (r_v1) begin
            r_prod <= PROD_W'(r_ma * r_mb);
        end
    end

    logic signed [ACC_W-1:0] rnd_sum;
    logic signed [ACC_W-1:0] shifted;
    logic signed [ACC_W:0]   total;

    always_comb begin
        if (r_lin) begin
            rnd_sum = r_acc + RND_LIN;
            shifted = rnd_sum >>> 16;
            total   = (ACC_W + 1)'(shifted) + (ACC_W + 1)'(r_a);
        end else begin
            rnd_sum = r_acc + RND_SINC;
            shifted = rnd_sum >>> 30;
            total   = (ACC_W + 1)'(shifted);
        end
        if (total > SAT_MAX) begin
            o_value = 16'sh7FFF;
        end else if (total < SAT_MIN) begin
            o_value = -16'sh8000;
        end else begin
            o_value = 16'(total);
        end
    end

    assign o_sts.busy      = (r_state != wsi_pkg::ST_IDLE);
    assign o_sts.res_valid = (r_state == wsi_pkg::ST_DONE);

endmodule

`default_nettype wire

/* design/windowed_sinc_interpolator_unit.sv */
// Windowed sinc interpolator top level: APB mode register, input handshake and
// output register around wsi_core. Depends on wsi_pkg and wsi_core.
`timescale 1ns / 1ps
`default_nettype none

// A push transfer (func 0) shifts the sample into the history and returns
// nothing. A query transfer (func 1) returns one saturated Q1.15 value.
// In sinc mode a query walks every history tap through the single
// multiply-accumulate against the registered weight ROM; in linear mode it
// goes through the same multiplier. Input ready is low while a query is in
// flight. The result sits in an output register, so a new item may be taken
// while it waits. Weights come from a ROM of 2^PHASE_BITS phases built at
// elaboration.

module windowed_sinc_interpolator_unit #(
    parameter int TAP_RADIUS = wsi_pkg::DEF_TAP_RADIUS,
    parameter int PHASE_BITS = wsi_pkg::DEF_PHASE_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_func,
    input  wire logic signed [15:0] i_sample,
    input  wire logic [15:0]        i_frac,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [15:0]      o_value,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic               r_mode;
    logic               r_out_valid;
    logic signed [15:0] r_value;

    wsi_pkg::t_cmd      cmd;
    wsi_pkg::t_sts      sts;
    logic               start;
    logic               res_take;
    logic signed [15:0] core_value;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == wsi_pkg::REG_MODE_IDX) ? {31'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= wsi_pkg::MODE_SINC;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == wsi_pkg::REG_MODE_IDX) begin
            r_mode <= pwdata[0];
        end
    end

    assign o_in_ready = !sts.busy;
    assign start      = i_in_valid && o_in_ready;
    assign cmd.query  = i_func;
    assign cmd.sample = i_sample;
    assign cmd.frac   = i_frac;
    assign res_take   = !r_out_valid || i_out_ready;

    wsi_core #(
        .TAP_RADIUS (TAP_RADIUS),
        .PHASE_BITS (PHASE_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (cmd),
        .i_mode     (r_mode),
        .i_res_take (res_take),
        .o_sts      (sts),
        .o_value    (core_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (sts.res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sts.res_valid && res_take) begin
            r_value <= core_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;

endmodule

`default_nettype wire

/* test/windowed_sinc_interpolator_unit_test.sv */
// Self-checking bench for windowed_sinc_interpolator_unit: random pushes and queries in both
// interpolation modes, checked against an in-bench fixed-point model of the weight ROM.
// Depends on wsi_pkg and the design top level.
`timescale 1ns / 1ps

module windowed_sinc_interpolator_unit_test;

    localparam int TAP_RADIUS = 16;
    localparam int PHASE_BITS = 6;
    localparam int TAPS       = 2 * TAP_RADIUS + 1;
    localparam int PHASES     = 1 << PHASE_BITS;

    localparam logic [2:0] MODE_ADDR = 3'd0;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 600;
    localparam int SETTLE_CYCLES  = 50;
    localparam int PHASE_ITEMS    = 140;
    localparam int PHASE_COUNT    = 8;

    typedef longint unsigned u64_t;

    localparam longint Q30    = 64'sd1073741824;
    localparam longint ONE24  = 64'sd16777216;
    localparam u64_t   PI_Q30 = 64'd3373259426;
    localparam longint K042   = 64'sd450971566;
    localparam longint K008   = 64'sd85899346;
    localparam longint HALF29 = 64'sd536870912;

    class interp_scoreboard;
        int                 weights [PHASES][TAPS];
        logic signed [15:0] history [TAPS];
        logic               mode;
        logic signed [15:0] expected_values [$];
        int                 mismatches;

        // sin(pi*t), t in Q8.24 half-turns, result Q2.30
        function longint sin_half_turn(logic [31:0] t_in);
            logic [31:0] t;
            logic        neg;
            u64_t        x;
            u64_t        x2;
            u64_t        term;
            int          k;
            t   = t_in & 32'h01FF_FFFF;
            neg = (t >= 32'h0100_0000);
            if (neg) begin
                t = t - 32'h0100_0000;
            end
            if (t > 32'h0080_0000) begin
                t = 32'h0100_0000 - t;
            end
            x    = (u64_t'(t) * PI_Q30) >> 24;
            x2   = (x * x) >> 30;
            term = u64_t'(Q30);
            for (k = 12; k >= 2; k -= 2) begin
                term = u64_t'(Q30) - ((x2 * term) >> 30) / u64_t'(k * (k + 1));
            end
            x = (x * term) >> 30;
            return neg ? -longint'(x) : longint'(x);
        endfunction

        function longint cos_half_turn(logic [31:0] t);
            return sin_half_turn(t + 32'h0080_0000);
        endfunction

        function new();
            longint      row [TAPS];
            longint      norm;
            longint      d;
            longint      mag;
            longint      snc;
            longint      num;
            longint      den;
            longint      bw;
            longint      q;
            logic [31:0] u;
            int          p;
            int          j;
            for (p = 0; p < PHASES; p++) begin
                norm = 0;
                for (j = 0; j < TAPS; j++) begin
                    d   = (longint'(p) <<< (24 - PHASE_BITS)) - longint'(j - TAP_RADIUS) * ONE24;
                    mag = (d < 0) ? -d : d;
                    if (mag > longint'(TAP_RADIUS) * ONE24) begin
                        row[j] = 0;
                    end else begin
                        if (mag == 0) begin
                            snc = Q30;
                        end else begin
                            num = sin_half_turn(d[31:0]);
                            if (d < 0) begin
                                num = -num;
                            end
                            den = longint'((u64_t'(mag) * PI_Q30) >> 24);
                            snc = (num * Q30) / den;
                        end
                        u      = 32'(mag / longint'(TAP_RADIUS));
                        bw     = K042 + cos_half_turn(u) / 2
                                 + (K008 * cos_half_turn(u * 32'd2)) / Q30;
                        row[j] = (snc * bw) / Q30;
                    end
                    norm += row[j];
                end
                for (j = 0; j < TAPS; j++) begin
                    q = (norm == 0) ? 0 : (row[j] * Q30) / norm;
                    if (q > 64'sd2147483647) begin
                        q = 64'sd2147483647;
                    end
                    if (q < -64'sd2147483648) begin
                        q = -64'sd2147483648;
                    end
                    weights[p][j] = int'(q);
                end
            end
            foreach (history[i]) begin
                history[i] = '0;
            end
            mode       = wsi_pkg::MODE_SINC;
            mismatches = 0;
        endfunction

        function void set_mode(logic m);
            mode = m;
        endfunction

        function int pending();
            return expected_values.size();
        endfunction

        function void note_transfer(logic f, logic signed [15:0] s, logic [15:0] r);
            longint acc;
            longint v;
            longint a;
            longint b;
            longint rr;
            int     idx;
            int     k;
            if (f == wsi_pkg::FUNC_PUSH) begin
                for (k = TAPS - 1; k > 0; k--) begin
                    history[k] = history[k - 1];
                end
                history[0] = s;
            end else begin
                if (mode == wsi_pkg::MODE_SINC) begin
                    idx = int'(r >> (16 - PHASE_BITS));
                    acc = 0;
                    for (k = 0; k < TAPS; k++) begin
                        acc += longint'(history[2 * TAP_RADIUS - k]) * longint'(weights[idx][k]);
                    end
                    v = (acc + HALF29) >>> 30;
                end else begin
                    a  = history[TAP_RADIUS];
                    b  = history[TAP_RADIUS - 1];
                    rr = r;
                    v  = a + ((rr * (b - a) + 64'sd32768) >>> 16);
                end
                if (v > 32767) begin
                    v = 32767;
                end
                if (v < -32768) begin
                    v = -32768;
                end
                expected_values.push_back(16'(v));
            end
        endfunction

        function void check_value(logic signed [15:0] got);
            logic signed [15:0] want;
            if (expected_values.size() == 0) begin
                $error("value: no result expected, got %0d", got);
                mismatches++;
            end else begin
                want = expected_values.pop_front();
                if (got !== want) begin
                    $error("value: expected %0d, got %0d", want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_func    = wsi_pkg::FUNC_PUSH;
    logic signed [15:0] in_sample  = '0;
    logic [15:0]        in_frac    = '0;
    logic               out_ready  = 1'b0;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [2:0]         paddr      = '0;
    logic [31:0]        pwdata     = '0;
    wire logic          o_in_ready;
    wire logic          o_out_valid;
    wire logic signed [15:0] o_value;
    wire logic [31:0]   prdata;
    wire logic          pready;

    interp_scoreboard sb;
    int results_seen   = 0;
    int stall_count    = 0;
    int reg_mismatches = 0;

    windowed_sinc_interpolator_unit #(
        .TAP_RADIUS (TAP_RADIUS),
        .PHASE_BITS (PHASE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (in_func),
        .i_sample    (in_sample),
        .i_frac      (in_frac),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_value     (o_value),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready && paddr == MODE_ADDR) begin
                sb.set_mode(pwdata[0]);
            end
            if (o_out_valid && out_ready) begin
                sb.check_value(o_value);
                results_seen++;
            end
            if (in_valid && o_in_ready) begin
                sb.note_transfer(in_func, in_sample, in_frac);
            end
            if ((psel && penable && pwrite && pready) || (o_out_valid && out_ready)
                || (in_valid && o_in_ready)) begin
                stall_count = 0;
            end else begin
                stall_count++;
            end
        end
    end

    initial begin : watchdog
        wait (stall_count >= WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // receiver: changing stall patterns, plus one long hold-off to back the block up
    initial begin : receiver
        int  style;
        int  left;
        int  cyc;
        bit  held;
        style = 0;
        left  = 0;
        cyc   = 0;
        held  = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 150) begin
                held      = 1'b1;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (left == 0) begin
                style = $urandom_range(0, 3);
                left  = $urandom_range(20, 200);
            end
            left--;
            cyc++;
            case (style)
                0: begin
                    out_ready = 1'b1;
                end
                1: begin
                    out_ready = ($urandom_range(0, 3) != 0);
                end
                2: begin
                    out_ready = ((cyc % 7) < 3);
                end
                default: begin
                    out_ready = 1'($urandom_range(0, 1));
                end
            endcase
        end
    end

    task automatic send_item(input logic f, input logic [15:0] s, input logic [15:0] r);
        @(negedge i_clk);
        in_valid  = 1'b1;
        in_func   = f;
        in_sample = s;
        in_frac   = r;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_mode_reg(input logic want);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = MODE_ADDR;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[0] !== want) begin
            $error("interp_mode: expected %0d, got %0d", want, prdata[0]);
            reg_mismatches++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_interp_mode(input logic m);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = MODE_ADDR;
        pwdata  = {31'($urandom_range(0, 32'h7FFF_FFFF)), m};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        check_mode_reg(m);
    endtask

    task automatic run_phase(input int n_items, input int sample_style);
        int          query_pct;
        int          burst;
        int          gap;
        int          n;
        bit          toggle;
        logic        f;
        logic [15:0] s;
        logic [15:0] r;
        query_pct = $urandom_range(20, 60);
        burst     = 0;
        toggle    = 1'b0;
        for (n = 0; n < n_items; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                repeat (gap) begin
                    @(negedge i_clk);
                    in_valid = 1'b0;
                end
            end
            burst--;
            f = ($urandom_range(0, 99) < query_pct) ? wsi_pkg::FUNC_QUERY : wsi_pkg::FUNC_PUSH;
            case (sample_style)
                0: begin
                    s = 16'($urandom);
                end
                1: begin
                    s = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
                end
                2: begin
                    s = 16'($urandom_range(0, 600) - 300);
                end
                default: begin
                    toggle = ($urandom_range(0, 4) == 0) ? toggle : !toggle;
                    s      = toggle ? 16'h7FFF : 16'h8000;
                end
            endcase
            case ($urandom_range(0, 7))
                0: begin
                    r = {6'($urandom), 10'h000};
                end
                1: begin
                    r = {6'($urandom), 10'h3FF};
                end
                2: begin
                    r = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                end
                default: begin
                    r = 16'($urandom);
                end
            endcase
            send_item(f, s, r);
        end
    endtask

    initial begin : stimulus
        int ph;
        sb = new();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        check_mode_reg(wsi_pkg::MODE_SINC);

        // sinc mode straight from reset: empty history, then extremes near the newest end
        send_item(wsi_pkg::FUNC_QUERY, 16'($urandom), 16'hFFFF);
        send_item(wsi_pkg::FUNC_PUSH, 16'h7FFF, 16'($urandom));
        send_item(wsi_pkg::FUNC_PUSH, 16'h8000, 16'($urandom));
        send_item(wsi_pkg::FUNC_PUSH, 16'h7FFF, 16'($urandom));
        send_item(wsi_pkg::FUNC_PUSH, 16'h8000, 16'($urandom));
        send_item(wsi_pkg::FUNC_PUSH, 16'h0000, 16'($urandom));
        send_item(wsi_pkg::FUNC_QUERY, 16'($urandom), 16'h0000);
        send_item(wsi_pkg::FUNC_QUERY, 16'($urandom), 16'hFFFF);
        send_item(wsi_pkg::FUNC_QUERY, 16'($urandom), 16'h8000);
        send_item(wsi_pkg::FUNC_QUERY, 16'($urandom), 16'h03FF);
        send_item(wsi_pkg::FUNC_QUERY, 16'($urandom), 16'h0400);
        drain();

        // linear mode: walk the extremes onto the centre pair
        set_interp_mode(wsi_pkg::MODE_LINEAR);
        repeat (12) send_item(wsi_pkg::FUNC_PUSH, 16'($urandom_range(0, 2) - 1), 16'($urandom));
        send_item(wsi_pkg::FUNC_QUERY, 16'($urandom), 16'hFFFF);
        send_item(wsi_pkg::FUNC_QUERY, 16'($urandom), 16'h8000);
        send_item(wsi_pkg::FUNC_QUERY, 16'($urandom), 16'h0001);
        send_item(wsi_pkg::FUNC_PUSH, 16'($urandom), 16'($urandom));
        send_item(wsi_pkg::FUNC_QUERY, 16'($urandom), 16'hFFFF);
        send_item(wsi_pkg::FUNC_QUERY, 16'($urandom), 16'h0000);
        drain();

        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            set_interp_mode((ph % 2 == 0) ? wsi_pkg::MODE_SINC : wsi_pkg::MODE_LINEAR);
            run_phase(PHASE_ITEMS, (ph / 2) % 4);
            drain();
        end

        if (sb.mismatches == 0 && reg_mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
design/wsi_pkg.sv
design/wsi_core.sv
design/windowed_sinc_interpolator_unit.sv
test/windowed_sinc_interpolator_unit_test.sv
